>>> src/sfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer package
// Shared widths, codes, table entry and result word types, step helpers.
// ----------------------------------------------------------------------------
package sfs_pkg;

   localparam int MAX_FRAMES = 64;
   localparam int POS_W      = $clog2(MAX_FRAMES);
   localparam int CNT_W      = $clog2(MAX_FRAMES + 1);

   localparam int MODE_W     = 2;
   localparam int SLOT_W     = 6;
   localparam int WORD_W     = 16;
   localparam int USER_WORDS = 4;
   localparam int TYPE_W     = 2;
   localparam int FC_W       = 7;
   localparam int STATE_W    = 2;
   localparam int FPOS_W     = 6;
   localparam int TIME_W     = 32;
   localparam int FRAC_BITS  = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // input item modes
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEGIN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

   // playback types
   localparam logic [TYPE_W-1:0] ANIM_ONCE = 2'd0;
   localparam logic [TYPE_W-1:0] ANIM_LOOP = 2'd1;
   localparam logic [TYPE_W-1:0] ANIM_YOYO = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ANIM_TYPE   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 1'd1;

   localparam logic DIR_FWD = 1'b0;
   localparam logic DIR_BWD = 1'b1;

   typedef enum logic [STATE_W-1:0] {
      ST_NONE    = 2'd0,
      ST_PLAYING = 2'd1,
      ST_STOPPED = 2'd2
   } play_state_type;

   typedef logic [USER_WORDS-1:0][WORD_W-1:0] user_words_type;

   typedef struct packed {
      logic [WORD_W-1:0] frame_id;
      logic [WORD_W-1:0] delay;
      user_words_type    user;
   } entry_type;

   typedef struct packed {
      logic [WORD_W-1:0]  shown_frame;
      logic [STATE_W-1:0] anim_state;
      logic [FPOS_W-1:0]  frame_position;
      user_words_type     user;
   } rsp_type;

   typedef struct packed {
      logic             stop;
      logic             reload;
      logic [POS_W-1:0] pos;
      logic             dir;
   } step_type;

   function automatic logic [CNT_W-1:0] eff_count(input logic [FC_W-1:0] fc);
      logic [CNT_W-1:0] cnt;
      if (fc == '0) begin
         cnt = CNT_W'(1);
      end else if (32'(fc) > MAX_FRAMES) begin
         cnt = CNT_W'(MAX_FRAMES);
      end else begin
         cnt = CNT_W'(fc);
      end
      return cnt;
   endfunction

   // Where one frame step would land from the given position and direction.
   function automatic step_type next_step(input logic [TYPE_W-1:0] anim,
                                          input logic [CNT_W-1:0]  count,
                                          input logic [POS_W-1:0]  pos,
                                          input logic              dir);
      step_type         st;
      logic [CNT_W-1:0] up;
      logic [CNT_W-1:0] down;
      up     = CNT_W'(pos) + CNT_W'(1);
      down   = CNT_W'(pos) - CNT_W'(1);
      st.stop   = 1'b0;
      st.reload = 1'b0;
      st.pos    = pos;
      st.dir    = dir;
      case (anim)
         ANIM_ONCE: begin
            if (up >= count) begin
               st.stop = 1'b1;
            end else begin
               st.pos = POS_W'(up);
            end
         end
         ANIM_LOOP: begin
            if (up >= count) begin
               st.pos    = '0;
               st.reload = 1'b1;
            end else begin
               st.pos = POS_W'(up);
            end
         end
         ANIM_YOYO: begin
            if (count < CNT_W'(2)) begin
               st.stop = 1'b1;
            end else if (dir == DIR_BWD) begin
               if (pos == '0) begin
                  st.dir = DIR_FWD;
                  st.pos = POS_W'(1);
               end else if (down >= count) begin
                  st.pos = POS_W'(count - CNT_W'(2));
               end else begin
                  st.pos = POS_W'(down);
               end
            end else begin
               if (up >= count) begin
                  st.dir = DIR_BWD;
                  st.pos = POS_W'(count - CNT_W'(2));
               end else begin
                  st.pos = POS_W'(up);
               end
            end
         end
         default: begin
            st.stop = 1'b1;
         end
      endcase
      return st;
   endfunction

endpackage
`default_nettype wire

>>> src/sfs_frame_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame table
// One write port, a registered read at the step target and a registered read
// of entry 0, both forwarding a write to the same entry in the same cycle.
// ----------------------------------------------------------------------------
module sfs_frame_mem
   import sfs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [POS_W-1:0] wr_addr,
   input  wire entry_type        wr_entry,
   input  wire logic [POS_W-1:0] rd_addr,
   output entry_type             rd_data,
   output entry_type             rd0_data
);

   entry_type mem [MAX_FRAMES];
   entry_type rd_data_ff;
   entry_type rd0_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr == rd_addr)) begin
         rd_data_ff <= wr_entry;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en && (wr_addr == '0)) begin
         rd0_data_ff <= wr_entry;
      end else begin
         rd0_data_ff <= mem[0];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd0_data = rd0_data_ff;

endmodule
`default_nettype wire

>>> src/sfs_rsp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry queue between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module sfs_rsp_fifo
   import sfs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         has_room,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   rsp_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && !has_room))
      else $error("result word pushed into a full buffer");

   a_push_pop_keeps_count: assert property (@(posedge clock) disable iff (reset)
      push && pop |=> $stable(count_ff))
      else $error("buffer count moved on a push with pop");
`endif

endmodule
`default_nettype wire

>>> src/sprite_frame_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite frame sequencer
// Plays a frame table once, in a loop or ping-pong, stepping on time ticks.
// ----------------------------------------------------------------------------
//   channel  prefix  dir  carries
//   request  req_    in   load / begin / tick word with entry data and dt
//   response rsp_    out  shown frame, state, position, user words
//   config   csr_    in   register index and write data (always ready)
//
// One item per cycle while the buffer has room: each accepted word updates
// the state and pushes its result in the same cycle to the buffer at rsp_.
// The step target entry and entry 0 are read ahead every cycle from the
// table, so a tick never waits on the memory port.
// Reset clears the play state, time, position and registers; the table
// holds garbage until loaded. A two-word result buffer keeps req_ready high
// through one stalled result.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer
   import sfs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [SLOT_W-1:0]     req_slot,
   input  wire logic [WORD_W-1:0]     req_frame_id,
   input  wire logic [WORD_W-1:0]     req_delay,
   input  wire logic signed [WORD_W-1:0] req_load_user_0,
   input  wire logic signed [WORD_W-1:0] req_load_user_1,
   input  wire logic signed [WORD_W-1:0] req_load_user_2,
   input  wire logic signed [WORD_W-1:0] req_load_user_3,
   input  wire logic [WORD_W-1:0]     req_dt,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [WORD_W-1:0]          rsp_shown_frame,
   output logic [STATE_W-1:0]         rsp_anim_state,
   output logic [FPOS_W-1:0]          rsp_frame_position,
   output logic signed [WORD_W-1:0]   rsp_user_word_0,
   output logic signed [WORD_W-1:0]   rsp_user_word_1,
   output logic signed [WORD_W-1:0]   rsp_user_word_2,
   output logic signed [WORD_W-1:0]   rsp_user_word_3,

   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [TYPE_W-1:0]        anim_ff;
   logic [TYPE_W-1:0]        anim_in;
   logic [FC_W-1:0]          fc_ff;
   logic [FC_W-1:0]          fc_in;
   logic signed [TIME_W-1:0] time_left_ff;
   logic signed [TIME_W-1:0] time_left_in;
   logic [POS_W-1:0]         position_ff;
   logic [POS_W-1:0]         position_in;
   logic                     direction_ff;
   logic                     direction_in;
   play_state_type           play_state_ff;
   play_state_type           play_state_in;
   logic [WORD_W-1:0]        displayed_ff;
   logic [WORD_W-1:0]        displayed_in;
   user_words_type           cur_user_ff;
   user_words_type           cur_user_in;

   logic                     accept;
   logic [CNT_W-1:0]         count;
   step_type                 step;
   step_type                 step_ahead;
   logic signed [TIME_W:0]   diff;
   logic signed [TIME_W-1:0] ticked;
   logic signed [TIME_W-1:0] tgt_delay;
   logic signed [TIME_W-1:0] zero_delay;
   logic                     load_hit;
   entry_type                wr_entry;
   entry_type                tgt_entry;
   entry_type                zero_entry;
   rsp_type                  rsp_word;
   rsp_type                  out_word;
   logic                     has_room;

   assign csr_ready = 1'b1;
   assign req_ready = has_room;
   assign accept    = req_valid && has_room;
   assign count     = eff_count(fc_ff);
   assign step      = next_step(anim_ff, count, position_ff, direction_ff);

   assign wr_entry.frame_id = req_frame_id;
   assign wr_entry.delay    = req_delay;
   assign wr_entry.user     = {req_load_user_3, req_load_user_2,
                               req_load_user_1, req_load_user_0};
   assign load_hit = accept && (req_mode == MODE_LOAD) && (CNT_W'(req_slot) < count);

   assign tgt_delay  = TIME_W'(tgt_entry.delay) << FRAC_BITS;
   assign zero_delay = TIME_W'(zero_entry.delay) << FRAC_BITS;

   // saturating subtract at the signed minimum
   always_comb begin
      diff = {time_left_ff[TIME_W-1], time_left_ff} - (TIME_W + 1)'(req_dt);
      if (diff[TIME_W] != diff[TIME_W-1]) begin
         ticked = {1'b1, {(TIME_W - 1){1'b0}}};
      end else begin
         ticked = diff[TIME_W-1:0];
      end
   end

   always_comb begin
      anim_in = anim_ff;
      fc_in   = fc_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ANIM_TYPE:   anim_in = csr_wdata[TYPE_W-1:0];
            CSR_FRAME_COUNT: fc_in   = csr_wdata[FC_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      time_left_in  = time_left_ff;
      position_in   = position_ff;
      direction_in  = direction_ff;
      play_state_in = play_state_ff;
      displayed_in  = displayed_ff;
      cur_user_in   = cur_user_ff;
      if (accept) begin
         case (req_mode)
            MODE_LOAD: begin
               if (load_hit && (POS_W'(req_slot) == position_ff)) begin
                  cur_user_in = wr_entry.user;
               end
            end
            MODE_BEGIN: begin
               position_in   = '0;
               displayed_in  = zero_entry.frame_id;
               cur_user_in   = zero_entry.user;
               time_left_in  = zero_delay;
               play_state_in = ST_PLAYING;
               direction_in  = DIR_FWD;
            end
            MODE_TICK: begin
               if (play_state_ff == ST_PLAYING) begin
                  time_left_in = ticked;
                  if (ticked < 0) begin
                     if (step.stop) begin
                        play_state_in = ST_STOPPED;
                     end else begin
                        position_in  = step.pos;
                        direction_in = step.dir;
                        displayed_in = tgt_entry.frame_id;
                        cur_user_in  = tgt_entry.user;
                        time_left_in = step.reload ? tgt_delay : ticked + tgt_delay;
                     end
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // read ahead the entry the next step would land on
   assign step_ahead = next_step(anim_in, eff_count(fc_in), position_in, direction_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         anim_ff       <= ANIM_ONCE;
         fc_ff         <= FC_W'(1);
         time_left_ff  <= '0;
         position_ff   <= '0;
         direction_ff  <= DIR_FWD;
         play_state_ff <= ST_NONE;
         displayed_ff  <= '0;
      end else begin
         anim_ff       <= anim_in;
         fc_ff         <= fc_in;
         time_left_ff  <= time_left_in;
         position_ff   <= position_in;
         direction_ff  <= direction_in;
         play_state_ff <= play_state_in;
         displayed_ff  <= displayed_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_user_ff <= cur_user_in;
   end

   sfs_frame_mem u_frame_mem (
      .clock    (clock),
      .wr_en    (load_hit),
      .wr_addr  (POS_W'(req_slot)),
      .wr_entry (wr_entry),
      .rd_addr  (step_ahead.pos),
      .rd_data  (tgt_entry),
      .rd0_data (zero_entry)
   );

   assign rsp_word.shown_frame    = displayed_in;
   assign rsp_word.anim_state     = STATE_W'(play_state_in);
   assign rsp_word.frame_position = FPOS_W'(position_in);
   assign rsp_word.user           = cur_user_in;

   sfs_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_word),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_word)
   );

   assign rsp_shown_frame    = out_word.shown_frame;
   assign rsp_anim_state     = out_word.anim_state;
   assign rsp_frame_position = out_word.frame_position;
   assign rsp_user_word_0    = out_word.user[0];
   assign rsp_user_word_1    = out_word.user[1];
   assign rsp_user_word_2    = out_word.user[2];
   assign rsp_user_word_3    = out_word.user[3];

`ifndef SYNTHESIS
   a_begin_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_BEGIN)
      |=> (play_state_ff == ST_PLAYING) && (position_ff == '0) && (direction_ff == DIR_FWD))
      else $error("begin did not restart at frame zero");

   a_idle_tick_holds_time: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_TICK) && (play_state_ff != ST_PLAYING)
      |=> $stable(time_left_ff))
      else $error("tick outside play changed the timer");

   a_none_means_no_time: assert property (@(posedge clock) disable iff (reset)
      (play_state_ff == ST_NONE) |-> (time_left_ff == '0))
      else $error("timer moved before any begin");
`endif

endmodule
`default_nettype wire

>>> tb/sfs_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer result checker
// Watches the request, response and register channels, keeps its own copy of
// the frame table and playback state, and checks every response word against
// the view of the sequencer that the accepted request should produce.
// ----------------------------------------------------------------------------
module sfs_result_checker
   import sfs_pkg::*;
(
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   input  wire logic                        req_ready,
   input  wire logic [MODE_W-1:0]           req_mode,
   input  wire logic [SLOT_W-1:0]           req_slot,
   input  wire logic [WORD_W-1:0]           req_frame_id,
   input  wire logic [WORD_W-1:0]           req_delay,
   input  wire logic signed [WORD_W-1:0]    req_load_user_0,
   input  wire logic signed [WORD_W-1:0]    req_load_user_1,
   input  wire logic signed [WORD_W-1:0]    req_load_user_2,
   input  wire logic signed [WORD_W-1:0]    req_load_user_3,
   input  wire logic [WORD_W-1:0]           req_dt,

   input  wire logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire logic [WORD_W-1:0]           rsp_shown_frame,
   input  wire logic [STATE_W-1:0]          rsp_anim_state,
   input  wire logic [FPOS_W-1:0]           rsp_frame_position,
   input  wire logic signed [WORD_W-1:0]    rsp_user_word_0,
   input  wire logic signed [WORD_W-1:0]    rsp_user_word_1,
   input  wire logic signed [WORD_W-1:0]    rsp_user_word_2,
   input  wire logic signed [WORD_W-1:0]    rsp_user_word_3,

   input  wire logic                        csr_valid,
   input  wire logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata,

   output int                               mismatch_count,
   output int                               pending_count
);

   logic [WORD_W-1:0]        id_mem    [MAX_FRAMES];
   logic [WORD_W-1:0]        delay_mem [MAX_FRAMES];
   user_words_type           user_mem  [MAX_FRAMES];
   logic signed [TIME_W-1:0] time_left;
   logic [POS_W-1:0]         cur_pos;
   logic                     cur_dir;
   play_state_type           cur_state;
   logic [WORD_W-1:0]        cur_frame;
   logic [TYPE_W-1:0]        cur_anim;
   logic [FC_W-1:0]          cur_fc;
   rsp_type                  frame_view_q [$];
   int                       errs = 0;

   function automatic int active_frames();
      if (cur_fc == '0) return 1;
      if (int'(cur_fc) > MAX_FRAMES) return MAX_FRAMES;
      return int'(cur_fc);
   endfunction

   function automatic logic signed [TIME_W-1:0] frame_time(input int p);
      return {8'd0, delay_mem[p], 8'd0};
   endfunction

   function automatic void jump_to(input int p);
      cur_pos   = POS_W'(p);
      cur_frame = id_mem[p];
   endfunction

   function automatic void advance_frame();
      int count;
      int nxt;
      count = active_frames();
      case (cur_anim)
         ANIM_ONCE: begin
            nxt = int'(cur_pos) + 1;
            if (nxt >= count) begin
               cur_state = ST_STOPPED;
            end else begin
               jump_to(nxt);
               time_left += frame_time(nxt);
            end
         end
         ANIM_LOOP: begin
            nxt = int'(cur_pos) + 1;
            if (nxt >= count) begin
               // wrap restarts the clock instead of carrying the overshoot
               jump_to(0);
               time_left = frame_time(0);
            end else begin
               jump_to(nxt);
               time_left += frame_time(nxt);
            end
         end
         ANIM_YOYO: begin
            if (count < 2) begin
               cur_state = ST_STOPPED;
            end else begin
               if (cur_dir == DIR_BWD) begin
                  if (cur_pos == '0) begin
                     cur_dir = DIR_FWD;
                     nxt = 1;
                  end else begin
                     nxt = int'(cur_pos) - 1;
                     if (nxt >= count) nxt = count - 2;
                  end
               end else begin
                  nxt = int'(cur_pos) + 1;
                  if (nxt >= count) begin
                     cur_dir = DIR_BWD;
                     nxt = count - 2;
                  end
               end
               jump_to(nxt);
               time_left += frame_time(nxt);
            end
         end
         default: begin
            cur_state = ST_STOPPED;
         end
      endcase
   endfunction

   function automatic void apply_word();
      longint  t;
      rsp_type v;
      case (req_mode)
         MODE_LOAD: begin
            if (int'(req_slot) < active_frames()) begin
               id_mem[req_slot]    = req_frame_id;
               delay_mem[req_slot] = req_delay;
               user_mem[req_slot]  = {req_load_user_3, req_load_user_2,
                                      req_load_user_1, req_load_user_0};
            end
         end
         MODE_BEGIN: begin
            jump_to(0);
            time_left = frame_time(0);
            cur_state = ST_PLAYING;
            cur_dir   = DIR_FWD;
         end
         MODE_TICK: begin
            if (cur_state == ST_PLAYING) begin
               t = longint'(time_left) - longint'(req_dt);
               // clamp at the most negative time instead of wrapping
               if (t < -64'sd2147483648) t = -64'sd2147483648;
               time_left = t[TIME_W-1:0];
               if (time_left < 0) advance_frame();
            end
         end
         default: ;
      endcase
      v.shown_frame    = cur_frame;
      v.anim_state     = cur_state;
      v.frame_position = cur_pos;
      v.user           = user_mem[cur_pos];
      frame_view_q.push_back(v);
   endfunction

   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      logic    bad;
      if (reset) begin
         time_left = '0;
         cur_pos   = '0;
         cur_dir   = DIR_FWD;
         cur_state = ST_NONE;
         cur_frame = '0;
         cur_anim  = ANIM_ONCE;
         cur_fc    = FC_W'(1);
         frame_view_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ANIM_TYPE:   cur_anim = csr_wdata[TYPE_W-1:0];
               CSR_FRAME_COUNT: cur_fc   = csr_wdata[FC_W-1:0];
               default: ;
            endcase
         end
         // queue the request first so a same-cycle response still finds it
         if (req_valid && req_ready) apply_word();
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_shown_frame, rsp_anim_state, rsp_frame_position,
                    rsp_user_word_3, rsp_user_word_2, rsp_user_word_1, rsp_user_word_0};
            if (frame_view_q.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%t: response word with nothing outstanding: frame %0d state %0d pos %0d",
                           $realtime, seen.shown_frame, seen.anim_state, seen.frame_position);
            end else begin
               want = frame_view_q.pop_front();
               bad = (seen.shown_frame !== want.shown_frame)
                  || (seen.anim_state !== want.anim_state)
                  || (seen.frame_position !== want.frame_position)
                  || (seen.user[0] !== want.user[0])
                  || (seen.user[1] !== want.user[1])
                  || (seen.user[2] !== want.user[2])
                  || (seen.user[3] !== want.user[3]);
               if (bad) begin
                  errs++;
                  if (errs <= 10)
                     $display({"%t: mismatch expected frame %0d state %0d pos %0d user %0d %0d %0d %0d",
                               " / got frame %0d state %0d pos %0d user %0d %0d %0d %0d"},
                              $realtime, want.shown_frame, want.anim_state, want.frame_position,
                              $signed(want.user[0]), $signed(want.user[1]),
                              $signed(want.user[2]), $signed(want.user[3]),
                              seen.shown_frame, seen.anim_state, seen.frame_position,
                              $signed(seen.user[0]), $signed(seen.user[1]),
                              $signed(seen.user[2]), $signed(seen.user[3]));
               end
            end
         end
      end
      mismatch_count <= errs;
      pending_count  <= frame_view_q.size();
   end

endmodule

>>> tb/tb_sprite_frame_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite frame sequencer testbench
// Drives load, begin and tick words through once, loop, ping-pong and
// unknown playback types over a sweep of frame counts, with random idle
// bursts on both channels and a long response hold-off. The checker judges
// every word.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer
   import sfs_pkg::*;
;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 8;
   localparam int STALL_LIMIT    = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_WORDS   = 1850;
   localparam int HOLD_AT        = 400;
   localparam int QUIET_FROM     = 1600;
   localparam int SETTLE_CYCLES  = 20;

   localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;
   localparam logic [TYPE_W-1:0] ANIM_HALT = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [SLOT_W-1:0] slot;
      logic [WORD_W-1:0] frame_id;
      logic [WORD_W-1:0] delay;
      logic [WORD_W-1:0] dt;
      user_words_type    user;
   } seq_word_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [MODE_W-1:0]           req_mode = MODE_LOAD;
   logic [SLOT_W-1:0]           req_slot = '0;
   logic [WORD_W-1:0]           req_frame_id = '0;
   logic [WORD_W-1:0]           req_delay = '0;
   logic signed [WORD_W-1:0]    req_load_user_0 = '0;
   logic signed [WORD_W-1:0]    req_load_user_1 = '0;
   logic signed [WORD_W-1:0]    req_load_user_2 = '0;
   logic signed [WORD_W-1:0]    req_load_user_3 = '0;
   logic [WORD_W-1:0]           req_dt = '0;

   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [WORD_W-1:0]           rsp_shown_frame;
   logic [STATE_W-1:0]          rsp_anim_state;
   logic [FPOS_W-1:0]           rsp_frame_position;
   logic signed [WORD_W-1:0]    rsp_user_word_0;
   logic signed [WORD_W-1:0]    rsp_user_word_1;
   logic signed [WORD_W-1:0]    rsp_user_word_2;
   logic signed [WORD_W-1:0]    rsp_user_word_3;

   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = CSR_ANIM_TYPE;
   logic [CSR_DATA_W-1:0]       csr_wdata = '0;

   int mismatch_count;
   int pending_count;
   int idle_cycles = 0;
   int frames_in_use = 1;
   int words_sent = 0;
   bit sender_gaps = 1'b1;
   bit receiver_stalls = 1'b1;
   bit hold_request = 1'b0;

   always #(HALF_PERIOD) clock = ~clock;

   sprite_frame_sequencer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_slot           (req_slot),
      .req_frame_id       (req_frame_id),
      .req_delay          (req_delay),
      .req_load_user_0    (req_load_user_0),
      .req_load_user_1    (req_load_user_1),
      .req_load_user_2    (req_load_user_2),
      .req_load_user_3    (req_load_user_3),
      .req_dt             (req_dt),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_shown_frame    (rsp_shown_frame),
      .rsp_anim_state     (rsp_anim_state),
      .rsp_frame_position (rsp_frame_position),
      .rsp_user_word_0    (rsp_user_word_0),
      .rsp_user_word_1    (rsp_user_word_1),
      .rsp_user_word_2    (rsp_user_word_2),
      .rsp_user_word_3    (rsp_user_word_3),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   sfs_result_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_slot           (req_slot),
      .req_frame_id       (req_frame_id),
      .req_delay          (req_delay),
      .req_load_user_0    (req_load_user_0),
      .req_load_user_1    (req_load_user_1),
      .req_load_user_2    (req_load_user_2),
      .req_load_user_3    (req_load_user_3),
      .req_dt             (req_dt),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_shown_frame    (rsp_shown_frame),
      .rsp_anim_state     (rsp_anim_state),
      .rsp_frame_position (rsp_frame_position),
      .rsp_user_word_0    (rsp_user_word_0),
      .rsp_user_word_1    (rsp_user_word_1),
      .rsp_user_word_2    (rsp_user_word_2),
      .rsp_user_word_3    (rsp_user_word_3),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // watchdog: any handshake on any channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // response side: ready streaks, stall bursts and one long hold-off
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            n = $urandom_range(1, 17);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            n = $urandom_range(1, 40);
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic logic [WORD_W-1:0] pick_delay();
      int roll;
      roll = $urandom_range(0, 39);
      if (roll == 0) return '1;
      if (roll == 1) return WORD_W'($urandom);
      if (roll < 6) return WORD_W'($urandom_range(4, 64));
      return WORD_W'($urandom_range(0, 3));
   endfunction

   function automatic logic [WORD_W-1:0] pick_dt();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return '1;
      if (roll == 1) return '0;
      if (roll == 2) return WORD_W'($urandom);
      return WORD_W'($urandom_range(1, 1023));
   endfunction

   function automatic seq_word_type random_word(input logic [MODE_W-1:0] mode);
      seq_word_type w;
      w.mode     = mode;
      w.slot     = SLOT_W'($urandom);
      w.frame_id = WORD_W'($urandom);
      w.delay    = pick_delay();
      w.dt       = pick_dt();
      w.user     = {$urandom, $urandom};
      return w;
   endfunction

   function automatic seq_word_type fixed_word(input logic [MODE_W-1:0] mode,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [WORD_W-1:0] frame_id,
                                               input logic [WORD_W-1:0] delay,
                                               input user_words_type    user,
                                               input logic [WORD_W-1:0] dt);
      seq_word_type w;
      w.mode     = mode;
      w.slot     = slot;
      w.frame_id = frame_id;
      w.delay    = delay;
      w.dt       = dt;
      w.user     = user;
      return w;
   endfunction

   function automatic seq_word_type tick_word(input logic [WORD_W-1:0] dt);
      seq_word_type w;
      w    = random_word(MODE_TICK);
      w.dt = dt;
      return w;
   endfunction

   task automatic send_word(input seq_word_type w);
      int n;
      if (sender_gaps && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= w.mode;
      req_slot        <= w.slot;
      req_frame_id    <= w.frame_id;
      req_delay       <= w.delay;
      req_dt          <= w.dt;
      req_load_user_0 <= w.user[0];
      req_load_user_1 <= w.user[1];
      req_load_user_2 <= w.user[2];
      req_load_user_3 <= w.user[3];
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // write both registers with the sequencer idle
   task automatic set_regs(input logic [TYPE_W-1:0] anim, input logic [FC_W-1:0] fc);
      drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_ANIM_TYPE;
      csr_wdata <= {6'($urandom), anim};
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_FRAME_COUNT;
      csr_wdata <= {1'($urandom), fc};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (fc == '0) frames_in_use = 1;
      else if (int'(fc) > MAX_FRAMES) frames_in_use = MAX_FRAMES;
      else frames_in_use = int'(fc);
   endtask

   task automatic run_phase(input logic [TYPE_W-1:0] anim, input logic [FC_W-1:0] fc,
                            input int n, input bit restart, input bit hold);
      seq_word_type w;
      int           pick;
      set_regs(anim, fc);
      if (hold) hold_request = 1'b1;
      // fill every entry in use so no step lands on an unwritten one
      for (int s = 0; s < frames_in_use; s++) begin
         w      = random_word(MODE_LOAD);
         w.slot = SLOT_W'(s);
         send_word(w);
      end
      if (restart) send_word(random_word(MODE_BEGIN));
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            w = random_word(MODE_TICK);
         end else if (pick < 84) begin
            w      = random_word(MODE_LOAD);
            w.slot = SLOT_W'($urandom_range(0, frames_in_use - 1));
         end else if (pick < 90) begin
            w = random_word(MODE_LOAD);
            if (frames_in_use < MAX_FRAMES)
               w.slot = SLOT_W'($urandom_range(frames_in_use, MAX_FRAMES - 1));
         end else if (pick < 96) begin
            w = random_word(MODE_BEGIN);
         end else begin
            w = random_word(MODE_NOP);
         end
         send_word(w);
      end
   endtask

   initial begin
      logic [TYPE_W-1:0] anim;
      logic [FC_W-1:0]   fc;
      bit                hold_done;
      bit                hold;
      hold_done  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // play once, single frame: idle tick, stop at the end, restart
      send_word(fixed_word(MODE_LOAD, 6'd0, 16'hFFFF, 16'h0000,
                           {16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000}, '0));
      send_word(tick_word(16'd100));
      send_word(random_word(MODE_NOP));
      send_word(fixed_word(MODE_LOAD, 6'd63, 16'h0000, 16'h0000, '0, '0));
      send_word(random_word(MODE_BEGIN));
      send_word(tick_word(16'd0));
      send_word(tick_word(16'd1));
      send_word(tick_word(16'hFFFF));
      send_word(random_word(MODE_BEGIN));

      // zero frame count behaves as one; loop wraps onto the same frame
      set_regs(ANIM_LOOP, FC_W'(0));
      send_word(tick_word(16'hFFFF));
      send_word(tick_word(16'd1));

      // ping-pong over three frames, turning at both ends
      set_regs(ANIM_YOYO, FC_W'(3));
      send_word(fixed_word(MODE_LOAD, 6'd1, 16'h0000, 16'h0001, {4{16'h8000}}, '0));
      send_word(fixed_word(MODE_LOAD, 6'd2, 16'h1234, 16'h0000, {4{16'h7FFF}}, '0));
      send_word(fixed_word(MODE_LOAD, 6'd0, 16'h0000, 16'h0000, '0, '0));
      send_word(random_word(MODE_BEGIN));
      send_word(tick_word(16'd300));
      send_word(tick_word(16'd0));
      send_word(tick_word(16'd0));
      send_word(tick_word(16'd1000));
      send_word(tick_word(16'd0));

      // unknown type stops on expiry; ping-pong stops below two frames
      set_regs(ANIM_HALT, FC_W'(3));
      send_word(tick_word(16'hFFFF));
      set_regs(ANIM_YOYO, FC_W'(1));
      send_word(random_word(MODE_BEGIN));
      send_word(tick_word(16'hFFFF));

      while (words_sent < RANDOM_WORDS) begin
         hold = !hold_done && words_sent >= HOLD_AT;
         if (words_sent >= QUIET_FROM) begin
            sender_gaps     = 1'b0;
            receiver_stalls = 1'b0;
         end else begin
            sender_gaps     = !hold && $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 7) == 7) anim = ANIM_HALT;
         else anim = TYPE_W'($urandom_range(0, 2));
         case ($urandom_range(0, 11))
            0:       fc = FC_W'(0);
            1:       fc = FC_W'(1);
            2:       fc = FC_W'(2);
            3:       fc = FC_W'(MAX_FRAMES);
            4:       fc = FC_W'($urandom_range(MAX_FRAMES + 1, 127));
            5:       fc = FC_W'($urandom_range(9, MAX_FRAMES - 1));
            default: fc = FC_W'($urandom_range(2, 8));
         endcase
         run_phase(anim, fc, hold ? 150 : $urandom_range(40, 120),
                   $urandom_range(0, 3) != 0, hold);
         if (hold) hold_done = 1'b1;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> sprite_frame_sequencer.f
src/sfs_pkg.sv
src/sfs_frame_mem.sv
src/sfs_rsp_fifo.sv
src/sprite_frame_sequencer.sv
tb/sfs_result_checker.sv
tb/tb_sprite_frame_sequencer.sv
